FILE: rtl/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg: shared types and codes for the cycle time sensor
// Event kinds, input function codes and sequencer states.
// ----------------------------------------------------------------------------
package cts_pkg;

    typedef enum logic [1:0] {
        FN_TICK    = 2'd0,
        FN_START   = 2'd1,
        FN_STOP    = 2'd2,
        FN_ENABLE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        EV_ACTIVE   = 3'd0,
        EV_TIME     = 3'd1,
        EV_FRACTION = 3'd2,
        EV_CYCLE    = 3'd3,
        EV_START    = 3'd4,
        EV_STOP     = 3'd5,
        EV_ENABLED  = 3'd6
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MOD,
        ST_DIV,
        ST_EMIT
    } state_t;

    localparam int unsigned MAX_EV = 5;

endpackage

FILE: rtl/cycle_time_sensor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycle_time_sensor_top: animation cycle timer
// Sequence: a tick runs the bit-serial modulo when looping, then the bit-serial
// division, then emits its events in order, each held until m_tready.
// One item at a time: no new input is taken until the last event is out.
// Reset (rst_n, asynchronous) sets enabled, inactive, last start all ones,
// cycle interval 1000000 and single-cycle mode.
// ----------------------------------------------------------------------------
module cycle_time_sensor_top
    import cts_pkg::*;
#(
    parameter int TIME_BITS     = 48,
    parameter int FRACTION_BITS = 16
)(
    input  logic clk,
    input  logic rst_n,
    // func, time_now, new_value, enable_value (lowest first), zero filled
    input  logic [((2*TIME_BITS+3+7)/8)*8-1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // event_kind, event_time, time_value, fraction, active_flag
    output logic [((2*TIME_BITS+FRACTION_BITS+5+7)/8)*8-1:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_tlast,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [TIME_BITS-1:0] cfg_data
);
    localparam int TB = TIME_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int OW = ((2*TB+FB+5+7)/8)*8;
    localparam int IW = ((2*TB+3+7)/8)*8;
    localparam int CW = $clog2(TB+2);
    localparam logic [FB:0] FONE = {1'b1, {FB{1'b0}}};

    // configuration
    logic [TB-1:0] ci_reg;
    logic          loop_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg   <= TB'(1000000);
            loop_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
                ci_reg <= cfg_data;
            else
                loop_reg <= cfg_data[0];
        end
    end

    // input fields
    logic [1:0]    in_func;
    logic [TB-1:0] in_now, in_val;
    logic          in_en;
    assign in_func = s_tdata[1:0];
    assign in_now  = s_tdata[TB+1:2];
    assign in_val  = s_tdata[2*TB+1:TB+2];
    assign in_en   = s_tdata[2*TB+2];

    // state
    state_t state_reg, state_next;
    logic active_reg, active_next, enabled_reg, enabled_next;
    logic [TB-1:0] start_reg, start_next, stop_reg, stop_next;
    logic [TB-1:0] lstart_reg, lstart_next, cur_reg, cur_next;
    logic [FB:0]   pfrac_reg, pfrac_next;
    logic [1:0]    func_reg, func_next;
    logic [TB-1:0] now_reg, now_next, val_reg, val_next;
    logic          en_reg, en_next;
    // serial divider: remainder, dividend shifter, quotient, count
    logic [TB:0]   rem_reg, rem_next;
    logic [TB-1:0] dsh_reg, dsh_next;
    logic [FB:0]   q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          fone_reg, fone_next;  // fraction forced to 1.0
    logic          stopped_reg, stopped_next;
    logic [TB-1:0] et_reg, et_next;      // event time for tick and disable events
    // event list
    logic [2:0]    evk_reg [MAX_EV], evk_next [MAX_EV];
    logic [TB-1:0] evt_reg [MAX_EV], evt_next [MAX_EV];
    logic [TB-1:0] evv_reg [MAX_EV], evv_next [MAX_EV];
    logic          eva_reg [MAX_EV], eva_next [MAX_EV];
    logic          evf_reg [MAX_EV], evf_next [MAX_EV]; // carries fraction
    logic [2:0]    ncnt_reg, ncnt_next, ptr_reg, ptr_next;

    logic [TB:0]   end_t;
    logic [TB-1:0] f_diff;
    logic [TB-1:0] act_t;                // time seen by the activation test
    logic          act_ok, last_ev;
    logic [FB:0]   frac_w;

    always_comb
    begin
        end_t  = {1'b0, start_reg} + {1'b0, ci_reg};
        f_diff = cur_reg - start_reg;
        act_t  = (func_reg == FN_TICK) ? now_reg : cur_reg;
        act_ok = !active_reg && start_reg <= act_t && start_reg != lstart_reg &&
                 (stop_reg < start_reg || stop_reg > act_t || loop_reg);
        frac_w  = fone_reg ? FONE : q_reg;
        last_ev = (ptr_reg + 3'd1 == ncnt_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        active_next = active_reg; enabled_next = enabled_reg;
        start_next = start_reg; stop_next = stop_reg; lstart_next = lstart_reg;
        cur_next = cur_reg; pfrac_next = pfrac_reg;
        func_next = func_reg; now_next = now_reg; val_next = val_reg; en_next = en_reg;
        rem_next = rem_reg; dsh_next = dsh_reg; q_next = q_reg; cnt_next = cnt_reg;
        fone_next = fone_reg; stopped_next = stopped_reg; et_next = et_reg;
        evk_next = evk_reg; evt_next = evt_reg; evv_next = evv_reg;
        eva_next = eva_reg; evf_next = evf_reg;
        ncnt_next = ncnt_reg; ptr_next = ptr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next = in_func; now_next = in_now;
                    val_next = in_val; en_next = in_en;
                    ncnt_next = 3'd0; ptr_next = 3'd0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_EMIT;
                case (func_reg)
                    FN_TICK:
                    begin
                        cur_next = now_reg;
                        if (!enabled_reg)
                            state_next = ST_IDLE;
                        else if (!active_reg)
                        begin
                            if (act_ok)
                            begin
                                active_next = 1'b1; lstart_next = start_reg;
                                evk_next[0] = EV_ACTIVE;   evt_next[0] = now_reg;
                                evv_next[0] = '0; eva_next[0] = 1'b1; evf_next[0] = 1'b0;
                                evk_next[1] = EV_TIME;     evt_next[1] = now_reg;
                                evv_next[1] = now_reg; eva_next[1] = 1'b0; evf_next[1] = 1'b0;
                                evk_next[2] = EV_FRACTION; evt_next[2] = now_reg;
                                evv_next[2] = '0; eva_next[2] = 1'b0; evf_next[2] = 1'b0;
                                evk_next[3] = EV_CYCLE;    evt_next[3] = now_reg;
                                evv_next[3] = now_reg; eva_next[3] = 1'b0; evf_next[3] = 1'b0;
                                ncnt_next = 3'd4;
                            end
                            // no activation: nothing to report
                            if (!act_ok)
                                state_next = ST_IDLE;
                        end
                        else
                        begin
                            // deactivation and elapsed time
                            stopped_next = 1'b0;
                            et_next = now_reg;
                            if ((stop_reg > start_reg && stop_reg <= now_reg) ||
                                (!loop_reg && end_t <= {1'b0, now_reg}))
                            begin
                                active_next = 1'b0; stopped_next = 1'b1;
                                start_next = '0;
                                if (end_t < {1'b0, stop_reg} || stop_reg < start_reg)
                                    et_next = end_t[TB-1:0];
                                else
                                    et_next = stop_reg;
                            end
                            cur_next = et_next;
                            if (ci_reg != '0 && et_next > start_reg)
                                dsh_next = et_next - start_reg;
                            else
                                dsh_next = '0;
                            if (!loop_reg && dsh_next > ci_reg)
                                dsh_next = ci_reg;
                            rem_next = '0; cnt_next = '0;
                            state_next = loop_reg ? ST_MOD : ST_DIV;
                            if (!loop_reg)
                            begin
                                rem_next = {1'b0, dsh_next}; q_next = '0;
                                fone_next = (dsh_next == '0) || (dsh_next >= ci_reg);
                            end
                        end
                    end
                    FN_START:
                    begin
                        if (!active_reg)
                        begin
                            start_next = val_reg;
                            evk_next[0] = EV_START; evt_next[0] = now_reg;
                            evv_next[0] = val_reg; eva_next[0] = 1'b0; evf_next[0] = 1'b0;
                            ncnt_next = 3'd1;
                        end
                        else
                            state_next = ST_IDLE;
                    end
                    FN_STOP:
                    begin
                        stop_next = val_reg;
                        evk_next[0] = EV_STOP; evt_next[0] = now_reg;
                        evv_next[0] = val_reg; eva_next[0] = 1'b0; evf_next[0] = 1'b0;
                        ncnt_next = 3'd1;
                        if (active_reg && val_reg > start_reg && val_reg <= cur_reg)
                        begin
                            active_next = 1'b0;
                            evk_next[1] = EV_ACTIVE; evt_next[1] = cur_reg;
                            evv_next[1] = '0; eva_next[1] = 1'b0; evf_next[1] = 1'b0;
                            ncnt_next = 3'd2;
                        end
                    end
                    default:
                    begin
                        enabled_next = en_reg;
                        if (active_reg && !en_reg)
                        begin
                            active_next = 1'b0; cur_next = now_reg;
                            stopped_next = 1'b0; et_next = now_reg;
                            if (ci_reg != '0 && now_reg > start_reg)
                                dsh_next = now_reg - start_reg;
                            else
                                dsh_next = '0;
                            rem_next = '0; cnt_next = '0;
                            state_next = ST_MOD;
                        end
                        else
                        begin
                            if (en_reg && act_ok)
                            begin
                                active_next = 1'b1; lstart_next = start_reg;
                                evk_next[0] = EV_ACTIVE;   evt_next[0] = cur_reg;
                                evv_next[0] = '0; eva_next[0] = 1'b1; evf_next[0] = 1'b0;
                                evk_next[1] = EV_TIME;     evt_next[1] = cur_reg;
                                evv_next[1] = cur_reg; eva_next[1] = 1'b0; evf_next[1] = 1'b0;
                                evk_next[2] = EV_FRACTION; evt_next[2] = cur_reg;
                                evv_next[2] = '0; eva_next[2] = 1'b0; evf_next[2] = 1'b0;
                                evk_next[3] = EV_CYCLE;    evt_next[3] = cur_reg;
                                evv_next[3] = cur_reg; eva_next[3] = 1'b0; evf_next[3] = 1'b0;
                                evk_next[4] = EV_ENABLED;  evt_next[4] = now_reg;
                                evv_next[4] = '0; eva_next[4] = en_reg; evf_next[4] = 1'b0;
                                ncnt_next = 3'd5;
                            end
                            else
                            begin
                                evk_next[0] = EV_ENABLED;  evt_next[0] = now_reg;
                                evv_next[0] = '0; eva_next[0] = en_reg; evf_next[0] = 1'b0;
                                ncnt_next = 3'd1;
                            end
                        end
                    end
                endcase
            end
            ST_MOD:
            begin
                // restoring modulo, one dividend bit per cycle, MSB first
                if (ci_reg == '0)
                begin
                    rem_next = '0;
                    cnt_next = CW'(TB);
                end
                else
                begin
                    rem_next = {rem_reg[TB-1:0], dsh_reg[TB-1]};
                    if ({rem_reg[TB-1:0], dsh_reg[TB-1]} >= {1'b0, ci_reg})
                        rem_next = {rem_reg[TB-1:0], dsh_reg[TB-1]} - {1'b0, ci_reg};
                    dsh_next = {dsh_reg[TB-2:0], 1'b0};
                    cnt_next = cnt_reg + CW'(1);
                end
                if (cnt_next == CW'(TB))
                begin
                    cnt_next = '0; q_next = '0;
                    fone_next = (rem_next == '0) || (ci_reg == '0);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring fraction division, one quotient bit per cycle
                rem_next = {rem_reg[TB-1:0], 1'b0};
                q_next = {q_reg[FB-1:0], 1'b0};
                if ({rem_reg[TB-1:0], 1'b0} >= {1'b0, ci_reg} || rem_reg[TB])
                begin
                    rem_next = {rem_reg[TB-1:0], 1'b0} - {1'b0, ci_reg};
                    q_next[0] = 1'b1;
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(FB-1))
                begin
                    state_next = ST_EMIT;
                    if (func_reg == FN_TICK)
                    begin
                        evk_next[0] = EV_FRACTION; evt_next[0] = et_reg;
                        evv_next[0] = '0; eva_next[0] = 1'b0; evf_next[0] = 1'b1;
                        evk_next[1] = EV_TIME; evt_next[1] = et_reg;
                        evv_next[1] = et_reg; eva_next[1] = 1'b0; evf_next[1] = 1'b0;
                        ncnt_next = 3'd2;
                        evk_next[2] = EV_ACTIVE; evt_next[2] = et_reg;
                        evv_next[2] = '0; eva_next[2] = 1'b0; evf_next[2] = 1'b0;
                        if ((fone_reg ? FONE : q_next) < pfrac_reg)
                        begin
                            evk_next[2] = EV_CYCLE; evv_next[2] = et_reg;
                            evk_next[3] = EV_ACTIVE; evt_next[3] = et_reg;
                            evv_next[3] = '0; eva_next[3] = 1'b0; evf_next[3] = 1'b0;
                            ncnt_next = stopped_reg ? 3'd4 : 3'd3;
                        end
                        else
                            ncnt_next = stopped_reg ? 3'd3 : 3'd2;
                        pfrac_next = fone_reg ? FONE : q_next;
                    end
                    else
                    begin
                        evk_next[0] = EV_TIME; evt_next[0] = et_reg;
                        evv_next[0] = et_reg; eva_next[0] = 1'b0; evf_next[0] = 1'b0;
                        evk_next[1] = EV_FRACTION; evt_next[1] = et_reg;
                        evv_next[1] = '0; eva_next[1] = 1'b0; evf_next[1] = 1'b1;
                        evk_next[2] = EV_ACTIVE; evt_next[2] = et_reg;
                        evv_next[2] = '0; eva_next[2] = 1'b0; evf_next[2] = 1'b0;
                        evk_next[3] = EV_ENABLED; evt_next[3] = et_reg;
                        evv_next[3] = '0; eva_next[3] = en_reg; evf_next[3] = 1'b0;
                        ncnt_next = 3'd4;
                    end
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    ptr_next = ptr_reg + 3'd1;
                    if (last_ev)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            active_reg <= 1'b0; enabled_reg <= 1'b1;
            start_reg <= '0; stop_reg <= '0; lstart_reg <= '1; cur_reg <= '0;
            pfrac_reg <= '0; ncnt_reg <= '0; ptr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            active_reg <= active_next; enabled_reg <= enabled_next;
            start_reg <= start_next; stop_reg <= stop_next; lstart_reg <= lstart_next;
            cur_reg <= cur_next; pfrac_reg <= pfrac_next;
            ncnt_reg <= ncnt_next; ptr_reg <= ptr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next; now_reg <= now_next; val_reg <= val_next; en_reg <= en_next;
        rem_reg <= rem_next; dsh_reg <= dsh_next; q_reg <= q_next; cnt_reg <= cnt_next;
        fone_reg <= fone_next; stopped_reg <= stopped_next; et_reg <= et_next;
        evk_reg <= evk_next; evt_reg <= evt_next; evv_reg <= evv_next;
        eva_reg <= eva_next; evf_reg <= evf_next;
    end

    // output
    logic [2:0] p;
    assign p        = (ptr_reg < 3'(MAX_EV)) ? ptr_reg : 3'd0;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = last_ev;
    assign m_tdata  = OW'({eva_reg[p], (evf_reg[p] ? frac_w : {(FB+1){1'b0}}),
                           evv_reg[p], evt_reg[p], evk_reg[p]});

    // checks
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input and output open together");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (ncnt_reg != 3'd0 && ptr_reg < ncnt_reg))
        else $error("event pointer out of range");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == ST_DECIDE)
        else $error("accepted item not decoded");
    a_iw: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (IW > 2*TB)) else $error("input width");

endmodule
